>>> rtl/core/nits_pkg.sv
`default_nettype none

package nits_pkg;

  // Fixed field widths of the transaction ports and the length register.
  localparam int IDX_W = 8;
  localparam int VAL_W = 16;
  localparam int LEN_W = 9;

  // Function codes of an input transaction.
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // Register map and reset values.
  localparam logic             REG_TABLE_LENGTH = 1'b0;
  localparam logic [LEN_W-1:0] TABLE_LENGTH_RST = 9'd256;

  // Which table address the datapath reads.
  typedef enum logic [1:0] {
    RD_FIRST,
    RD_LAST,
    RD_MID,
    RD_NEIGHBOR
  } rd_sel_t;

  // Which index the datapath captures as the result.
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_LAST,
    RES_MID,
    RES_PICK
  } res_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     probe;
    logic     set_res;
    res_sel_t res_sel;
  } nits_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic lookup;
    logic le_first;
    logic ge_last;
    logic hit;
    logic search_end;
    logic edge_low;
    logic edge_high;
  } nits_status_t;

endpackage

`default_nettype wire

>>> rtl/core/nearest_index_table_search_top.sv
`default_nettype none

// Nearest-index search over an ascending table of 16-bit values. A transaction
// is taken when start is high and busy is low. A write transaction (func 0)
// stores one entry in the same cycle and gives no result; the block stays
// idle and busy stays low. A lookup transaction (func 1) gives one result on
// nearest_index, marked by a one-cycle done pulse that the receiver cannot
// stall, so it must take the result in that cycle. A lookup whose query lies
// at or past an end of the table raises done from the check of the first or
// the last entry. A full search probes midpoints and narrows the bounds until
// a hit or until the bounds cross, then may read one neighbor to pick the
// nearer index. busy falls at the edge that takes the result, and the next
// transaction can then be accepted. The search is bounded by the single read
// port of the table memory: each probe compares the entry read at the
// previous edge and reads the next midpoint. Entries must be written before a
// lookup can reach them; the table has no reset and no clearing pass.
module nearest_index_table_search_top #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  output logic                            done,
  input  wire logic                       func,
  input  wire logic [nits_pkg::IDX_W-1:0] entry_index,
  input  wire logic [nits_pkg::VAL_W-1:0] entry_value,
  input  wire logic [nits_pkg::VAL_W-1:0] query_value,
  output logic [nits_pkg::IDX_W-1:0]      nearest_index,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [nits_pkg::LEN_W-1:0] table_length;
  logic                       cfg_wr;
  nits_pkg::nits_cmd_t        cmd;
  nits_pkg::nits_status_t     status;

  // Configuration register; a write lands in the access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[2] == nits_pkg::REG_TABLE_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= nits_pkg::TABLE_LENGTH_RST;
    end else if (cfg_wr) begin
      table_length <= pwdata[nits_pkg::LEN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == nits_pkg::REG_TABLE_LENGTH) ? 32'(table_length) : '0;

  // Search sequencer.
  nits_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // Table memory, bounds and compare logic.
  nits_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .table_length  (table_length),
    .func          (func),
    .entry_index   (entry_index),
    .entry_value   (entry_value),
    .query_value   (query_value),
    .cmd           (cmd),
    .status        (status),
    .nearest_index (nearest_index)
  );

endmodule

`default_nettype wire

>>> rtl/core/nits_datapath.sv
`default_nettype none

module nits_datapath #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic                           clk,
  input  wire logic [nits_pkg::LEN_W-1:0]     table_length,
  input  wire logic                           func,
  input  wire logic [nits_pkg::IDX_W-1:0]     entry_index,
  input  wire logic [nits_pkg::VAL_W-1:0]     entry_value,
  input  wire logic [nits_pkg::VAL_W-1:0]     query_value,
  input  wire nits_pkg::nits_cmd_t            cmd,
  output nits_pkg::nits_status_t              status,
  output logic [nits_pkg::IDX_W-1:0]          nearest_index
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int LW = (AW + 1 > 10) ? AW + 1 : 10;
  localparam int IW = (AW + 1 > 8) ? AW + 1 : 8;
  localparam logic [AW-1:0] LAST_MAX = AW'(TABLE_DEPTH - 1);
  localparam logic [LW-1:0] DEPTH_L  = LW'(TABLE_DEPTH);
  localparam logic [IW-1:0] DEPTH_I  = IW'(TABLE_DEPTH);

  // Table storage.
  logic [nits_pkg::VAL_W-1:0] mem [TABLE_DEPTH];

  logic [nits_pkg::VAL_W-1:0] q;
  logic [nits_pkg::VAL_W-1:0] rdata;
  logic [nits_pkg::VAL_W-1:0] tmid;
  logic [AW-1:0]              last;
  logic [AW-1:0]              lo;
  logic [AW-1:0]              hi;
  logic [AW-1:0]              mid;
  logic [AW-1:0]              res_idx;

  logic [LW-1:0]              len_w;
  logic [AW-1:0]              last_load;
  logic [IW-1:0]              widx;
  logic                       wr_ok;
  logic                       probe_gt;
  logic [AW-1:0]              lo_next;
  logic [AW-1:0]              hi_next;
  logic [AW:0]                mid_sum;
  logic [AW-1:0]              mid_c;
  logic                       go_low;
  logic [AW-1:0]              rd_addr;
  logic [nits_pkg::VAL_W-1:0] da;
  logic [nits_pkg::VAL_W-1:0] db;
  logic [AW-1:0]              pick_idx;
  logic [IW-1:0]              res_w;

  // Clamp the configured length into 1..TABLE_DEPTH and take the last index.
  always_comb begin
    len_w = LW'(table_length);
    if (len_w == '0) begin
      last_load = '0;
    end else if (len_w > DEPTH_L) begin
      last_load = LAST_MAX;
    end else begin
      last_load = AW'(len_w - LW'(1));
    end
  end

  // A write beyond the table depth is dropped.
  assign widx  = IW'(entry_index);
  assign wr_ok = (widx < DEPTH_I);

  // Bound update of one probe and the next midpoint.
  assign probe_gt = (rdata > q);

  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (cmd.probe) begin
      if (probe_gt) begin
        hi_next = mid - AW'(1);
      end else begin
        lo_next = mid + AW'(1);
      end
    end
  end

  assign mid_sum = (AW + 1)'(lo_next) + (AW + 1)'(hi_next);
  assign mid_c   = mid_sum[AW:1];

  // Side of the last probe on which the query fell.
  assign go_low = (q < tmid);

  // Read address selection.
  always_comb begin
    case (cmd.rd_sel)
      nits_pkg::RD_FIRST:    rd_addr = '0;
      nits_pkg::RD_LAST:     rd_addr = last;
      nits_pkg::RD_MID:      rd_addr = mid_c;
      nits_pkg::RD_NEIGHBOR: rd_addr = go_low ? (mid - AW'(1)) : (mid + AW'(1));
      default:               rd_addr = '0;
    endcase
  end

  // Nearer of the two neighbors; a tie goes to the higher index.
  always_comb begin
    if (go_low) begin
      da       = tmid - q;
      db       = q - rdata;
      pick_idx = (da <= db) ? mid : (mid - AW'(1));
    end else begin
      da       = rdata - q;
      db       = q - tmid;
      pick_idx = (da <= db) ? (mid + AW'(1)) : mid;
    end
  end

  // Table write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.load && (func == nits_pkg::FUNC_WRITE) && wr_ok) begin
      mem[widx[AW-1:0]] <= entry_value;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Search registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q    <= query_value;
      last <= last_load;
      lo   <= '0;
      hi   <= last_load;
    end
    if (cmd.probe) begin
      lo   <= lo_next;
      hi   <= hi_next;
      tmid <= rdata;
    end
    if (cmd.rd_en && (cmd.rd_sel == nits_pkg::RD_MID)) begin
      mid <= mid_c;
    end
    if (cmd.set_res) begin
      case (cmd.res_sel)
        nits_pkg::RES_ZERO: res_idx <= '0;
        nits_pkg::RES_LAST: res_idx <= last;
        nits_pkg::RES_MID:  res_idx <= mid;
        nits_pkg::RES_PICK: res_idx <= pick_idx;
        default:            res_idx <= '0;
      endcase
    end
  end

  // Status to the controller.
  always_comb begin
    status.lookup     = (func == nits_pkg::FUNC_LOOKUP);
    status.le_first   = (q <= rdata);
    status.ge_last    = (q >= rdata);
    status.hit        = (rdata == q);
    status.search_end = (lo_next > hi_next);
    status.edge_low   = go_low && (mid == '0);
    status.edge_high  = !go_low && (mid >= last);
  end

  // The reported index is masked to the port width.
  assign res_w         = IW'(res_idx);
  assign nearest_index = res_w[nits_pkg::IDX_W-1:0];

endmodule

`default_nettype wire

>>> rtl/core/nits_ctrl.sv
`default_nettype none

module nits_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire nits_pkg::nits_status_t status,
  output nits_pkg::nits_cmd_t         cmd,
  output logic                        busy,
  output logic                        done
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK_FIRST,
    S_CHK_LAST,
    S_PROBE,
    S_FINISH,
    S_PICK,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and datapath commands.
  always_comb begin
    state_next  = state;
    cmd.load    = 1'b0;
    cmd.rd_en   = 1'b0;
    cmd.rd_sel  = nits_pkg::RD_FIRST;
    cmd.probe   = 1'b0;
    cmd.set_res = 1'b0;
    cmd.res_sel = nits_pkg::RES_ZERO;
    case (state)
      S_IDLE: begin
        // A write completes at acceptance; a lookup reads the first entry.
        if (start) begin
          cmd.load = 1'b1;
          if (status.lookup) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = nits_pkg::RD_FIRST;
            state_next = S_CHK_FIRST;
          end
        end
      end
      S_CHK_FIRST: begin
        if (status.le_first) begin
          cmd.set_res = 1'b1;
          cmd.res_sel = nits_pkg::RES_ZERO;
          state_next  = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = nits_pkg::RD_LAST;
          state_next = S_CHK_LAST;
        end
      end
      S_CHK_LAST: begin
        if (status.ge_last) begin
          cmd.set_res = 1'b1;
          cmd.res_sel = nits_pkg::RES_LAST;
          state_next  = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = nits_pkg::RD_MID;
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        // Compare the probed entry; on a miss narrow the bounds and, until they cross, read the next one.
        if (status.hit) begin
          cmd.set_res = 1'b1;
          cmd.res_sel = nits_pkg::RES_MID;
          state_next  = S_DONE;
        end else begin
          cmd.probe = 1'b1;
          if (status.search_end) begin
            state_next = S_FINISH;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = nits_pkg::RD_MID;
          end
        end
      end
      S_FINISH: begin
        if (status.edge_low) begin
          cmd.set_res = 1'b1;
          cmd.res_sel = nits_pkg::RES_ZERO;
          state_next  = S_DONE;
        end else if (status.edge_high) begin
          cmd.set_res = 1'b1;
          cmd.res_sel = nits_pkg::RES_LAST;
          state_next  = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = nits_pkg::RD_NEIGHBOR;
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        cmd.set_res = 1'b1;
        cmd.res_sel = nits_pkg::RES_PICK;
        state_next  = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and registered handshake outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
      done  <= (state_next == S_DONE);
    end
  end

endmodule

`default_nettype wire
